>>> rtl/bbfc_pkg.sv
// Package with the constants, codes and types shared by the buddy free-set block.
`default_nettype none
package bbfc_pkg;

	// Memory of 2^ADDR_BITS units, with one free bit per block at every level.
	localparam int ADDR_BITS = 10;
	localparam int MAP_W     = ADDR_BITS + 1;
	localparam int MAP_DEPTH = 1 << MAP_W;

	// Widths of the payload fields.
	localparam int REQ_W    = 2;
	localparam int LVL_W    = 4;
	localparam int ADDR_W   = 10;
	localparam int STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_QUERY = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_DOUBLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_OWN,
		S_BUDDY,
		S_MARK,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> rtl/buddy_block_free_coalesce.sv
// Top level of the buddy-system free set with coalescing on free.
`default_nettype none
// The block keeps one free bit for every buddy block of a memory of 2^ADDR_BITS
// units (ADDR_BITS is 10), at every level from one unit up to the whole memory,
// in a single 2^(ADDR_BITS+1) by 1 RAM. After reset the block runs a clearing
// pass that writes one RAM entry per cycle, and in_ready stays low until the
// pass is done. Each input transfer names a block by level and start address
// and carries a request type: a load marks the block free, a free marks it
// free and merges it with its buddy for as long as the buddy is free, and a
// query reports the block's free bit. Every request gives exactly one result
// transfer. Misaligned or out-of-range blocks and unknown request types
// return status 1 and change nothing; loading or freeing a block whose bit is
// already set returns status 2 and changes nothing. One request is in work at
// a time: a sequencer drives one RAM read and at most one RAM write per cycle,
// and in each merge step the buddy clear and the next buddy read overlap. A
// load goes from S_CHECK through S_OWN and S_MARK to S_DONE; a free also
// passes S_BUDDY, where it stays while it merges, unless the block is the
// whole memory; a rejected request goes from S_CHECK straight to S_DONE, and
// a query or a double free from S_OWN to S_DONE. The block is idle again in
// the cycle after the result is loaded. The result sits in an output
// register; a new input is taken while that result waits, and the block
// stalls only if the next result is ready before the old one is taken.
module buddy_block_free_coalesce
	import bbfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [REQ_W-1:0]    req_type,
	input  wire logic [LVL_W-1:0]    level,
	input  wire logic [ADDR_W-1:0]   block_address,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [STATUS_W-1:0] status,
	output logic      [LVL_W-1:0]    final_level,
	output logic      [ADDR_W-1:0]   final_address,
	output logic                     is_free
);

	state_t state_q, state_d;

	// Request being worked on.
	logic [REQ_W-1:0]  req_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [ADDR_W-1:0] addr_q;
	logic [MAP_W-1:0]  idx_q;
	logic [MAP_W-1:0]  clr_q;

	// Result waiting for the output register.
	logic [STATUS_W-1:0] res_status_q;
	logic [LVL_W-1:0]    res_lvl_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                res_free_q;

	logic out_valid_q;

	// RAM port signals.
	logic             mem_we;
	logic [MAP_W-1:0] mem_waddr;
	logic             mem_wdata;
	logic [MAP_W-1:0] mem_raddr;
	logic             mem_rdata;

	logic             bad_req;
	logic [MAP_W-1:0] idx_calc;
	logic             lvl_top;
	logic             out_free;
	logic             in_xfer;
	logic [ADDR_W-1:0] lvl_bit;

	bbfc_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Request checks on the latched request: unknown type, level above the
	// whole memory, start beyond the memory, or start not aligned to the size.
	always_comb begin
		bad_req = (req_q != REQ_LOAD && req_q != REQ_FREE && req_q != REQ_QUERY)
			|| (32'(lvl_q) > 32'(ADDR_BITS))
			|| ((32'(addr_q) >> ADDR_BITS) != 32'd0)
			|| ((32'(addr_q) & ((32'd1 << lvl_q) - 32'd1)) != 32'd0);
	end

	// Map position of a block: a leading one marks the level, the address
	// bits above the block size follow. Buddy is this XOR 1, parent is this >> 1.
	assign idx_calc = (MAP_W'(1) << (ADDR_BITS - int'(lvl_q)))
		| (MAP_W'(addr_q) >> lvl_q);

	assign lvl_top  = (32'(lvl_q) == 32'(ADDR_BITS));
	assign lvl_bit  = ADDR_W'(1) << lvl_q;
	assign out_free = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = bad_req ? S_DONE : S_OWN;
			end
			S_OWN: begin
				if (req_q == REQ_QUERY || mem_rdata) begin
					state_d = S_DONE;
				end else if (req_q == REQ_FREE && !lvl_top) begin
					state_d = S_BUDDY;
				end else begin
					state_d = S_MARK;
				end
			end
			S_BUDDY: begin
				if (mem_rdata && (32'(lvl_q) + 32'd1 != 32'(ADDR_BITS))) begin
					state_d = S_BUDDY;
				end else begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Handshake and RAM port control.
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = 1'b0;
		mem_raddr = idx_q ^ MAP_W'(1);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_CHECK: begin
				mem_raddr = idx_calc;
			end
			S_OWN: begin
				mem_raddr = idx_q ^ MAP_W'(1);
			end
			S_BUDDY: begin
				// Clear the free buddy and look at the parent's buddy.
				mem_we    = mem_rdata;
				mem_waddr = idx_q ^ MAP_W'(1);
				mem_raddr = (idx_q >> 1) ^ MAP_W'(1);
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + MAP_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q  <= req_type;
			lvl_q  <= level;
			addr_q <= block_address;
		end
		case (state_q)
			S_CHECK: begin
				idx_q        <= idx_calc;
				res_status_q <= ST_BAD;
				res_lvl_q    <= '0;
				res_addr_q   <= '0;
				res_free_q   <= 1'b0;
			end
			S_OWN: begin
				if (req_q == REQ_QUERY) begin
					res_status_q <= ST_OK;
					res_lvl_q    <= lvl_q;
					res_addr_q   <= addr_q;
					res_free_q   <= mem_rdata;
				end else if (mem_rdata) begin
					res_status_q <= ST_DOUBLE;
				end
			end
			S_BUDDY: begin
				if (mem_rdata) begin
					addr_q <= addr_q & ~lvl_bit;
					lvl_q  <= lvl_q + LVL_W'(1);
					idx_q  <= idx_q >> 1;
				end
			end
			S_MARK: begin
				res_status_q <= ST_OK;
				res_lvl_q    <= lvl_q;
				res_addr_q   <= addr_q;
				res_free_q   <= 1'b0;
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			status        <= res_status_q;
			final_level   <= res_lvl_q;
			final_address <= res_addr_q;
			is_free       <= res_free_q;
		end
	end

	assign out_valid = out_valid_q;

	// A rejected request reports nothing but its status.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> final_level == '0 && final_address == '0 && !is_free)
		else $error("rejected result carries a block");

	// The free flag is only ever reported by an accepted query.
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_free |-> status == ST_OK)
		else $error("free flag with a non-ok status");

	// The map is written only while clearing, merging or marking.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_CLEAR || state_q == S_BUDDY || state_q == S_MARK)
		else $error("map write outside a write phase");

	// A merge step never runs at the top level, where there is no buddy.
	a_merge_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BUDDY |-> 32'(lvl_q) < 32'(ADDR_BITS))
		else $error("merge step at the top level");

	// A waiting result is dropped only by a transfer.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without a transfer");

endmodule
`default_nettype wire

>>> rtl/bbfc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bbfc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the buddy free set with coalescing on free.
module testbench;
	import bbfc_pkg::*;

	// Request type code that the block must reject.
	localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;

	// Number of random requests after the directed table.
	localparam int RANDOM_REQUESTS = 1350;
	localparam int DIRECTED_ROWS   = 25;

	// One result transfer, field by field.
	typedef struct packed {
		status_t             status;
		logic [LVL_W-1:0]    lvl;
		logic [ADDR_W-1:0]   addr;
		logic                is_free;
	} result_t;

	// One row of the directed table. When "typed" is set, the result is written
	// out by hand; otherwise it comes from the free-set predictor.
	typedef struct packed {
		logic [REQ_W-1:0]    req;
		logic [LVL_W-1:0]    lvl;
		logic [ADDR_W-1:0]   addr;
		logic                typed;
		result_t             want;
	} stim_row_t;

	// Clock and reset. All inputs hold known values from time zero.
	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic [REQ_W-1:0]    req_type      = '0;
	logic [LVL_W-1:0]    level         = '0;
	logic [ADDR_W-1:0]   block_address = '0;
	logic                out_ready     = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic [STATUS_W-1:0] status;
	logic [LVL_W-1:0]    final_level;
	logic [ADDR_W-1:0]   final_address;
	logic                is_free;

	always #10 clk = ~clk;

	buddy_block_free_coalesce DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.level         (level),
		.block_address (block_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.final_level   (final_level),
		.final_address (final_address),
		.is_free       (is_free)
	);

	// The testbench's own copy of the free bits, indexed like a heap: the whole
	// memory sits at entry 1, each block's buddy at index XOR 1, its parent at
	// index shifted right by one.
	logic free_bits [MAP_DEPTH];

	// Results that the block still owes, oldest first.
	result_t pending_results [$];
	result_t oldest;

	stim_row_t directed_rows [DIRECTED_ROWS];

	int mismatch_count = 0;
	int result_count   = 0;

	// Tallies for the closing summary.
	int loads_done   = 0;
	int frees_done   = 0;
	int merge_frees  = 0;
	int deepest_climb = 0;
	int queries_done = 0;
	int queries_hit  = 0;
	int rejects_seen = 0;
	int doubles_seen = 0;

	// Sender pacing: a burst of back-to-back transfers, then a gap.
	int burst_left = 0;

	// Most random stimulus works inside a 64-unit window for a while so that buddies
	// meet and frees coalesce, then moves to another window.
	int unsigned window_base = 0;
	int          window_left = 0;

	// Receiver stall pattern counter.
	int unsigned rx_cycle = 0;

	// Predicts the result of one accepted request and updates the free bits.
	function automatic result_t free_set_step(input logic [REQ_W-1:0] r,
			input logic [LVL_W-1:0] l, input logic [ADDR_W-1:0] a);
		result_t     res;
		int unsigned idx;
		int unsigned lv;
		int unsigned ad;
		res = '{status: ST_OK, lvl: '0, addr: '0, is_free: 1'b0};
		// Unknown request types, levels beyond the whole memory and blocks
		// that do not start on a multiple of their size are rejected untouched.
		if ((r != REQ_LOAD && r != REQ_FREE && r != REQ_QUERY) || l > ADDR_BITS ||
				(int'(a) & ((1 << l) - 1)) != 0) begin
			res.status = ST_BAD;
			return res;
		end
		lv  = l;
		ad  = a;
		idx = (1 << (ADDR_BITS - lv)) | (ad >> lv);
		if (r == REQ_QUERY) begin
			res.lvl     = l;
			res.addr    = a;
			res.is_free = free_bits[idx];
			return res;
		end
		// A load or free of a block that is already marked free is a double free.
		if (free_bits[idx]) begin
			res.status = ST_DOUBLE;
			return res;
		end
		// Climb while the buddy is free; the whole memory has no buddy.
		if (r == REQ_FREE) begin
			while (lv < ADDR_BITS && free_bits[idx ^ 1]) begin
				free_bits[idx ^ 1] = 1'b0;
				ad  = ad & ~(1 << lv);
				lv  = lv + 1;
				idx = idx >> 1;
			end
		end
		free_bits[idx] = 1'b1;
		res.lvl  = LVL_W'(lv);
		res.addr = ADDR_W'(ad);
		return res;
	endfunction

	function automatic stim_row_t mk_row(input logic [REQ_W-1:0] r, input int l, input int a,
			input logic typed, input status_t st, input int fl, input int fa, input logic fr);
		stim_row_t row;
		row.req          = r;
		row.lvl          = LVL_W'(l);
		row.addr         = ADDR_W'(a);
		row.typed        = typed;
		row.want.status  = st;
		row.want.lvl     = LVL_W'(fl);
		row.want.addr    = ADDR_W'(fa);
		row.want.is_free = fr;
		return row;
	endfunction

	// Holds the sender idle between bursts. Called before each request is presented.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			// Roughly a third of the bursts follow straight on with no gap.
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	// Presents one request and holds it until the transfer, then records what
	// the block must answer.
	task automatic transfer_request(input logic [REQ_W-1:0] r, input logic [LVL_W-1:0] l,
			input logic [ADDR_W-1:0] a, input logic typed, input result_t typed_res);
		result_t predicted;
		in_valid      <= 1'b1;
		req_type      <= r;
		level         <= l;
		block_address <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// The transfer happened at this edge. The predictor always runs so that
		// its free bits track the block, even where the row gives the answer.
		predicted = free_set_step(r, l, a);
		pending_results.push_back(typed ? typed_res : predicted);
		case (predicted.status)
			ST_BAD: begin
				rejects_seen++;
			end
			ST_DOUBLE: begin
				doubles_seen++;
			end
			default: begin
				if (r == REQ_LOAD) begin
					loads_done++;
				end else if (r == REQ_FREE) begin
					frees_done++;
					if (predicted.lvl > l) begin
						merge_frees++;
						if (int'(predicted.lvl) - int'(l) > deepest_climb)
							deepest_climb = int'(predicted.lvl) - int'(l);
					end
				end else begin
					queries_done++;
					if (predicted.is_free)
						queries_hit++;
				end
			end
		endcase
	endtask

	// Draws one random request. Most are well formed and land in the current
	// window; a few are raw noise that covers every bit of every field,
	// including the undefined request type, oversized levels and misalignment.
	task automatic draw_request(output logic [REQ_W-1:0] r, output logic [LVL_W-1:0] l,
			output logic [ADDR_W-1:0] a);
		int unsigned pick;
		int unsigned lv;
		int unsigned mask;
		if (window_left == 0) begin
			window_base = $urandom_range(0, 15) * 64;
			window_left = $urandom_range(20, 60);
		end
		window_left--;
		if ($urandom_range(0, 99) < 6) begin
			r = REQ_W'($urandom);
			l = LVL_W'($urandom);
			a = ADDR_W'($urandom);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 42)
				r = REQ_FREE;
			else if (pick < 72)
				r = REQ_LOAD;
			else if (pick < 97)
				r = REQ_QUERY;
			else
				r = REQ_UNDEFINED;
			if ($urandom_range(0, 9) < 8) begin
				lv   = $urandom_range(0, 6);
				mask = ~((1 << lv) - 1);
				a    = ADDR_W'(window_base + ($urandom_range(0, 63) & mask));
			end else begin
				lv   = $urandom_range(7, ADDR_BITS);
				mask = ~((1 << lv) - 1);
				a    = ADDR_W'($urandom_range(0, 1023) & mask);
			end
			l = LVL_W'(lv);
		end
	endtask

	// Receiver: checks every result transfer against the oldest expectation and
	// then picks its ready for the next cycle. The stall pattern steps in turn
	// through always ready, light random stalls, a fixed duty cycle, and heavy
	// random stalls.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Mismatch: result transfer with nothing pending: status %0d level %0d address %0d free %0b",
						status, final_level, final_address, is_free);
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status || final_level !== oldest.lvl ||
						final_address !== oldest.addr || is_free !== oldest.is_free) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch at result %0d: expected status %0d level %0d address %0d free %0b, got status %0d level %0d address %0d free %0b",
							result_count, oldest.status, oldest.lvl, oldest.addr, oldest.is_free,
							status, final_level, final_address, is_free);
				end
			end
		end
		rx_cycle++;
		case ((rx_cycle / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ((rx_cycle % 9) < 5);
			default: out_ready <= ($urandom_range(0, 2) == 0);
		endcase
	end

	// Main sequence: reset, the directed table, random requests, drain, verdict.
	initial begin
		logic [REQ_W-1:0]  r;
		logic [LVL_W-1:0]  l;
		logic [ADDR_W-1:0] a;

		for (int i = 0; i < MAP_DEPTH; i++)
			free_bits[i] = 1'b0;

		// Right after reset nothing is free, so the whole memory reads as taken.
		directed_rows[0]  = mk_row(REQ_QUERY, 10, 0, 1'b1, ST_OK, 10, 0, 1'b0);
		// Rejections: undefined type, level far and just beyond the top, and
		// blocks that do not start on a multiple of their size.
		directed_rows[1]  = mk_row(REQ_UNDEFINED, 0, 0, 1'b1, ST_BAD, 0, 0, 1'b0);
		directed_rows[2]  = mk_row(REQ_LOAD, 15, 0, 1'b1, ST_BAD, 0, 0, 1'b0);
		directed_rows[3]  = mk_row(REQ_FREE, 11, 0, 1'b1, ST_BAD, 0, 0, 1'b0);
		directed_rows[4]  = mk_row(REQ_QUERY, 3, 5, 1'b1, ST_BAD, 0, 0, 1'b0);
		directed_rows[5]  = mk_row(REQ_LOAD, 9, 256, 1'b1, ST_BAD, 0, 0, 1'b0);
		// Load the buddy of the unit block at zero at every level, so that the
		// next free climbs all the way up to the whole memory.
		for (int k = 0; k < ADDR_BITS; k++)
			directed_rows[6 + k] = mk_row(REQ_LOAD, k, 1 << k, 1'b1, ST_OK, k, 1 << k, 1'b0);
		directed_rows[16] = mk_row(REQ_FREE, 0, 0, 1'b0, ST_OK, 0, 0, 1'b0);
		directed_rows[17] = mk_row(REQ_QUERY, 10, 0, 1'b0, ST_OK, 0, 0, 1'b0);
		// The whole memory is now free: freeing it again is a double free.
		directed_rows[18] = mk_row(REQ_FREE, 10, 0, 1'b1, ST_DOUBLE, 0, 0, 1'b0);
		// Top unit: load, load again, query, then free its buddy to merge.
		directed_rows[19] = mk_row(REQ_LOAD, 0, 1023, 1'b1, ST_OK, 0, 1023, 1'b0);
		directed_rows[20] = mk_row(REQ_LOAD, 0, 1023, 1'b1, ST_DOUBLE, 0, 0, 1'b0);
		directed_rows[21] = mk_row(REQ_QUERY, 0, 1023, 1'b1, ST_OK, 0, 1023, 1'b1);
		directed_rows[22] = mk_row(REQ_FREE, 0, 1022, 1'b0, ST_OK, 0, 0, 1'b0);
		directed_rows[23] = mk_row(REQ_QUERY, 5, 992, 1'b0, ST_OK, 0, 0, 1'b0);
		directed_rows[24] = mk_row(REQ_QUERY, 0, 1023, 1'b0, ST_OK, 0, 0, 1'b0);

		// Reset is held low at first and released on a clock edge. The block then
		// clears its store and keeps in_ready low until it is done, which the first
		// handshake simply waits out.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			pace_sender();
			transfer_request(directed_rows[i].req, directed_rows[i].lvl, directed_rows[i].addr,
				directed_rows[i].typed, directed_rows[i].want);
		end

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			draw_request(r, l, a);
			pace_sender();
			transfer_request(r, l, a, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Drain, then leave room for the block's worst latency so that a stray
		// extra result would still be caught.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4 * (ADDR_BITS + 5)) @(posedge clk);

		$display("Covered %0d loads, %0d frees (%0d merged, up to %0d levels), %0d queries (%0d free)",
			loads_done, frees_done, merge_frees, deepest_climb, queries_done, queries_hit);
		$display("plus %0d rejected and %0d double-free requests; %0d results, %0d mismatches",
			rejects_seen, doubles_seen, result_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, clearing pass included.
	initial begin
		#5000000;
		$display("Timeout with %0d results still pending", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
